// ===== rtl/core/cbfm_pkg.sv =====
// ----------------------------------------------------------------------------
// cbfm_pkg
// shared constants, codes and the frame entry type of the frame manager
// ----------------------------------------------------------------------------
package cbfm_pkg;

  localparam int NumFrames = 16;
  localparam int FileBits  = 8;
  localparam int PageBits  = 24;
  localparam int PinBits   = 8;

  localparam int FrameW  = $clog2(NumFrames);
  localparam int TickW   = $clog2(2 * NumFrames + 1);
  localparam int PinCntW = $clog2(NumFrames + 1);

  // fixed port field widths
  localparam int ModeW    = 3;
  localparam int FileW    = 8;
  localparam int PageW    = 24;
  localparam int StatusW  = 3;
  localparam int FrameOutW = 4;

  localparam logic [PinBits-1:0] PinMax = {PinBits{1'b1}};

  localparam logic [ModeW-1:0] ModeRead    = 3'd0;
  localparam logic [ModeW-1:0] ModeUnpin   = 3'd1;
  localparam logic [ModeW-1:0] ModeAlloc   = 3'd2;
  localparam logic [ModeW-1:0] ModeDispose = 3'd3;
  localparam logic [ModeW-1:0] ModeFlush   = 3'd4;

  localparam logic [StatusW-1:0] StOk        = 3'd0;
  localparam logic [StatusW-1:0] StFull      = 3'd1;
  localparam logic [StatusW-1:0] StNotPinned = 3'd2;
  localparam logic [StatusW-1:0] StNotFound  = 3'd3;
  localparam logic [StatusW-1:0] StPinned    = 3'd4;
  localparam logic [StatusW-1:0] StPresent   = 3'd5;
  localparam logic [StatusW-1:0] StPinOvf    = 3'd6;

  typedef struct packed {
    logic                dirty;
    logic                refd;
    logic [PinBits-1:0]  pins;
    logic [FileBits-1:0] file;
    logic [PageBits-1:0] page;
  } entry_t;

endpackage

// ===== rtl/core/cbfm_if.sv =====
// ----------------------------------------------------------------------------
// cbfm_req_if / cbfm_rsp_if
// valid/ready channels carrying requests and results of the frame manager
// ----------------------------------------------------------------------------
interface cbfm_req_if;
  logic                          valid;
  logic                          ready;
  logic [cbfm_pkg::ModeW-1:0]    mode;
  logic [cbfm_pkg::FileW-1:0]    file_id;
  logic [cbfm_pkg::PageW-1:0]    page_no;
  logic                          mark_dirty;

  modport source (output valid, mode, file_id, page_no, mark_dirty, input ready);
  modport sink   (input valid, mode, file_id, page_no, mark_dirty, output ready);
endinterface

interface cbfm_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [cbfm_pkg::StatusW-1:0]    status;
  logic [cbfm_pkg::FrameOutW-1:0]  frame;
  logic                            fetch_needed;
  logic                            write_back;
  logic [cbfm_pkg::FileW-1:0]      victim_file;
  logic [cbfm_pkg::PageW-1:0]      victim_page;
  logic                            last;

  modport source (output valid, status, frame, fetch_needed, write_back, victim_file,
                  victim_page, last, input ready);
  modport sink   (input valid, status, frame, fetch_needed, write_back, victim_file,
                  victim_page, last, output ready);
endinterface

// ===== rtl/core/clock_buffer_frame_manager.sv =====
// ----------------------------------------------------------------------------
// clock_buffer_frame_manager
// frame table of a page buffer with second-chance (clock) replacement
// ----------------------------------------------------------------------------
//  channel  | dir | carries
//  ---------+-----+-----------------------------------------------------------
//  req_i    | in  | mode, file_id, page_no, mark_dirty
//  rsp_o    | out | status, frame, fetch_needed, write_back, victim_*, last
//
//  every frame look is a read step then an evaluate step on the entry memory
//  lookup scans the frames in order; a miss on read or alloc runs a clock sweep
//  of at most 2*NumFrames steps, each a read step then a decide step
//  flush walks all frames once, with a result per dirty frame and a final one,
//  but stops with a pinned status at the first pinned frame of the file
//  reset clears valid bits, the clock hand (to the last frame) and control;
//  the entry memory is not cleared. a full result register stalls the walk
//

module clock_buffer_frame_manager (
  input  logic clk_i,
  input  logic rst_ni,
  cbfm_req_if.sink   req_i,
  cbfm_rsp_if.source rsp_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FRD  = 3'd1; // lookup read
  localparam logic [2:0] S_FEV  = 3'd2; // lookup compare
  localparam logic [2:0] S_SRD  = 3'd3; // sweep step read
  localparam logic [2:0] S_SEV  = 3'd4; // sweep step decide
  localparam logic [2:0] S_LRD  = 3'd5; // flush read
  localparam logic [2:0] S_LEV  = 3'd6; // flush decide
  localparam logic [2:0] S_LEND = 3'd7; // flush final status

  localparam logic [cbfm_pkg::FrameW-1:0] LastIdx =
    cbfm_pkg::FrameW'(cbfm_pkg::NumFrames - 1);

  logic [2:0] state_q, state_d;
  logic [cbfm_pkg::FrameW-1:0] idx_q, idx_d, hand_q, hand_d, hand_nx;
  logic [cbfm_pkg::TickW-1:0] ticks_q, ticks_d;
  logic [cbfm_pkg::PinCntW-1:0] pinned_q, pinned_d;
  logic [cbfm_pkg::NumFrames-1:0] valid_q, valid_d;

  // latched request
  logic [cbfm_pkg::ModeW-1:0]    mode_q, mode_d;
  logic [cbfm_pkg::FileBits-1:0] file_q, file_d;
  logic [cbfm_pkg::PageBits-1:0] page_q, page_d;
  logic                          md_q, md_d;

  // entry memory
  cbfm_pkg::entry_t mem_q [cbfm_pkg::NumFrames];
  cbfm_pkg::entry_t rd_q, mem_wd;
  logic mem_we, mem_re;
  logic [cbfm_pkg::FrameW-1:0] mem_wa, mem_ra;

  // result register
  logic out_valid_q, out_free, emit;
  logic [cbfm_pkg::StatusW-1:0] e_status, st_q;
  logic [cbfm_pkg::FrameW-1:0] e_frame;
  logic [cbfm_pkg::FrameOutW-1:0] fr_q;
  logic e_fetch, e_wb, e_last, fetch_q, wb_q, last_q;
  logic [cbfm_pkg::FileBits-1:0] e_vf;
  logic [cbfm_pkg::PageBits-1:0] e_vp;
  logic [cbfm_pkg::FileW-1:0] vf_q;
  logic [cbfm_pkg::PageW-1:0] vp_q;

  logic hit, fmatch;

  assign req_i.ready = (state_q == S_IDLE);
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign hand_nx     = (hand_q == LastIdx) ? '0 : hand_q + 1'b1;
  assign hit    = valid_q[idx_q] && rd_q.file == file_q && rd_q.page == page_q;
  assign fmatch = valid_q[idx_q] && rd_q.file == file_q;

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    hand_d   = hand_q;
    ticks_d  = ticks_q;
    pinned_d = pinned_q;
    valid_d  = valid_q;
    mode_d   = mode_q;
    file_d   = file_q;
    page_d   = page_q;
    md_d     = md_q;
    mem_we   = 1'b0;
    mem_wa   = idx_q;
    mem_wd   = rd_q;
    mem_re   = 1'b0;
    mem_ra   = idx_q;
    emit     = 1'b0;
    e_status = cbfm_pkg::StOk;
    e_frame  = '0;
    e_fetch  = 1'b0;
    e_wb     = 1'b0;
    e_vf     = '0;
    e_vp     = '0;
    e_last   = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          mode_d = req_i.mode;
          file_d = cbfm_pkg::FileBits'(req_i.file_id);
          page_d = cbfm_pkg::PageBits'(req_i.page_no);
          md_d   = req_i.mark_dirty;
          idx_d  = '0;
          if (req_i.mode == cbfm_pkg::ModeRead || req_i.mode == cbfm_pkg::ModeUnpin ||
              req_i.mode == cbfm_pkg::ModeAlloc || req_i.mode == cbfm_pkg::ModeDispose) begin
            state_d = S_FRD;
          end else if (req_i.mode == cbfm_pkg::ModeFlush) begin
            state_d = S_LRD;
          end
          // unused modes are dropped
        end
      end

      S_FRD: begin
        mem_re  = 1'b1;
        state_d = S_FEV;
      end

      S_FEV: begin
        if (hit) begin
          if (out_free) begin
            emit    = 1'b1;
            e_frame = idx_q;
            state_d = S_IDLE;
            unique case (mode_q)
              cbfm_pkg::ModeRead: begin
                mem_we      = 1'b1;
                mem_wd.refd = 1'b1;
                if (rd_q.pins == cbfm_pkg::PinMax) begin
                  e_status = cbfm_pkg::StPinOvf;
                end else begin
                  mem_wd.pins = rd_q.pins + 1'b1;
                end
              end
              cbfm_pkg::ModeAlloc: e_status = cbfm_pkg::StPresent;
              cbfm_pkg::ModeUnpin: begin
                if (rd_q.pins == '0) begin
                  e_status = cbfm_pkg::StNotPinned;
                end else begin
                  mem_we       = 1'b1;
                  mem_wd.pins  = rd_q.pins - 1'b1;
                  mem_wd.dirty = rd_q.dirty | md_q;
                end
              end
              default: valid_d[idx_q] = 1'b0; // dispose
            endcase
          end
        end else if (idx_q == LastIdx) begin
          if (mode_q == cbfm_pkg::ModeRead || mode_q == cbfm_pkg::ModeAlloc) begin
            ticks_d  = '0;
            pinned_d = '0;
            state_d  = S_SRD;
          end else if (out_free) begin
            emit     = 1'b1;
            e_status = cbfm_pkg::StNotFound;
            state_d  = S_IDLE;
          end
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_FRD;
        end
      end

      S_SRD: begin
        if (ticks_q == cbfm_pkg::TickW'(2 * cbfm_pkg::NumFrames)) begin
          // one more tick would exceed the sweep limit
          if (out_free) begin
            hand_d   = hand_nx;
            emit     = 1'b1;
            e_status = cbfm_pkg::StFull;
            state_d  = S_IDLE;
          end
        end else begin
          hand_d  = hand_nx;
          ticks_d = ticks_q + 1'b1;
          mem_re  = 1'b1;
          mem_ra  = hand_nx;
          state_d = S_SEV;
        end
      end

      S_SEV: begin
        mem_wa = hand_q;
        if (!valid_q[hand_q] || (!rd_q.refd && rd_q.pins == '0)) begin
          // take this frame, writing back an evicted dirty page
          if (out_free) begin
            mem_we          = 1'b1;
            mem_wd.dirty    = 1'b0;
            mem_wd.refd     = 1'b1;
            mem_wd.pins     = cbfm_pkg::PinBits'(1);
            mem_wd.file     = file_q;
            mem_wd.page     = page_q;
            valid_d[hand_q] = 1'b1;
            emit            = 1'b1;
            e_frame         = hand_q;
            e_fetch         = (mode_q == cbfm_pkg::ModeRead);
            if (valid_q[hand_q] && rd_q.dirty) begin
              e_wb = 1'b1;
              e_vf = rd_q.file;
              e_vp = rd_q.page;
            end
            state_d = S_IDLE;
          end
        end else if (rd_q.refd) begin
          // second chance
          mem_we      = 1'b1;
          mem_wd.refd = 1'b0;
          state_d     = S_SRD;
        end else if (pinned_q == cbfm_pkg::PinCntW'(cbfm_pkg::NumFrames - 1)) begin
          if (out_free) begin
            emit     = 1'b1;
            e_status = cbfm_pkg::StFull;
            state_d  = S_IDLE;
          end
        end else begin
          pinned_d = pinned_q + 1'b1;
          state_d  = S_SRD;
        end
      end

      S_LRD: begin
        mem_re  = 1'b1;
        state_d = S_LEV;
      end

      S_LEV: begin
        if (fmatch && rd_q.pins != '0) begin
          if (out_free) begin
            emit     = 1'b1;
            e_status = cbfm_pkg::StPinned;
            e_frame  = idx_q;
            state_d  = S_IDLE;
          end
        end else if (fmatch && rd_q.dirty && !out_free) begin
          state_d = S_LEV; // wait for room in the result register
        end else begin
          if (fmatch) begin
            valid_d[idx_q] = 1'b0;
            if (rd_q.dirty) begin
              emit    = 1'b1;
              e_frame = idx_q;
              e_wb    = 1'b1;
              e_vf    = rd_q.file;
              e_vp    = rd_q.page;
              e_last  = 1'b0;
            end
          end
          if (idx_q == LastIdx) begin
            state_d = S_LEND;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_LRD;
          end
        end
      end

      default: begin // S_LEND
        if (out_free) begin
          emit    = 1'b1;
          state_d = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      hand_q      <= LastIdx;
      ticks_q     <= '0;
      pinned_q    <= '0;
      valid_q     <= '0;
      mode_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      hand_q   <= hand_d;
      ticks_q  <= ticks_d;
      pinned_q <= pinned_d;
      valid_q  <= valid_d;
      mode_q   <= mode_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request payload and result payload
  always_ff @(posedge clk_i) begin
    file_q <= file_d;
    page_q <= page_d;
    md_q   <= md_d;
    if (emit) begin
      st_q    <= e_status;
      fr_q    <= cbfm_pkg::FrameOutW'(e_frame);
      fetch_q <= e_fetch;
      wb_q    <= e_wb;
      vf_q    <= cbfm_pkg::FileW'(e_vf);
      vp_q    <= cbfm_pkg::PageW'(e_vp);
      last_q  <= e_last;
    end
  end

  // entry memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_ra];
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = st_q;
  assign rsp_o.frame        = fr_q;
  assign rsp_o.fetch_needed = fetch_q;
  assign rsp_o.write_back   = wb_q;
  assign rsp_o.victim_file  = vf_q;
  assign rsp_o.victim_page  = vp_q;
  assign rsp_o.last         = last_q;

endmodule

// ===== tb/cbfm_checker.sv =====
// ----------------------------------------------------------------------------
// cbfm_checker
// watches request and result channels, predicts the frame table and compares
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module cbfm_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  cbfm_req_if        req,
  cbfm_rsp_if        rsp,
  output int         fail_cnt_o,
  output int         pending_o
);
  import cbfm_pkg::*;

  typedef struct packed {
    logic [StatusW-1:0]   status;
    logic [FrameOutW-1:0] frame;
    logic                 fetch_needed;
    logic                 write_back;
    logic [FileW-1:0]     victim_file;
    logic [PageW-1:0]     victim_page;
    logic                 last;
  } result_t;

  // shadow frame table
  logic               f_valid [NumFrames];
  logic               f_dirty [NumFrames];
  logic               f_refd  [NumFrames];
  logic [PinBits-1:0] f_pins  [NumFrames];
  logic [FileW-1:0]   f_file  [NumFrames];
  logic [PageW-1:0]   f_page  [NumFrames];
  int                 hand;

  result_t expected_results [$];
  int      fails;

  assign fail_cnt_o = fails;
  assign pending_o  = expected_results.size();

  function automatic result_t mk(logic [StatusW-1:0] st, int fr, logic fe, logic wb,
                                 logic [FileW-1:0] vf, logic [PageW-1:0] vp, logic l);
    result_t r;
    r.status = st; r.frame = fr[FrameOutW-1:0]; r.fetch_needed = fe;
    r.write_back = wb; r.victim_file = vf; r.victim_page = vp; r.last = l;
    return r;
  endfunction

  function automatic int lookup(logic [FileW-1:0] f, logic [PageW-1:0] p);
    for (int i = 0; i < NumFrames; i++)
      if (f_valid[i] && f_file[i] == f && f_page[i] == p) return i;
    return -1;
  endfunction

  function automatic void free_frame(int i);
    f_valid[i] = 0; f_dirty[i] = 0; f_refd[i] = 0; f_pins[i] = '0;
  endfunction

  // clock sweep; -1 when the buffer is full
  function automatic int clock_sweep(output logic wb, output logic [FileW-1:0] vf,
                                     output logic [PageW-1:0] vp);
    int ticks, pinned;
    ticks = 0; pinned = 0; wb = 0; vf = '0; vp = '0;
    forever begin
      hand = (hand + 1) % NumFrames;
      ticks++;
      if (ticks > 2 * NumFrames) return -1;
      if (!f_valid[hand]) return hand;
      if (f_refd[hand]) begin
        f_refd[hand] = 0;
        continue;
      end
      if (f_pins[hand] == 0) begin
        if (f_dirty[hand]) begin
          wb = 1; vf = f_file[hand]; vp = f_page[hand];
        end
        free_frame(hand);
        return hand;
      end
      pinned++;
      if (pinned == NumFrames) return -1;
    end
  endfunction

  function automatic void predict_request(logic [ModeW-1:0] m, logic [FileW-1:0] f,
                                          logic [PageW-1:0] p, logic md);
    int s;
    logic wb;
    logic [FileW-1:0] vf;
    logic [PageW-1:0] vp;
    case (m)
      ModeRead, ModeAlloc: begin
        s = lookup(f, p);
        if (s >= 0) begin
          if (m == ModeAlloc) expected_results.push_back(mk(StPresent, s, 0, 0, 0, 0, 1));
          else begin
            f_refd[s] = 1;
            if (f_pins[s] == PinMax) expected_results.push_back(mk(StPinOvf, s, 0, 0, 0, 0, 1));
            else begin
              f_pins[s]++;
              expected_results.push_back(mk(StOk, s, 0, 0, 0, 0, 1));
            end
          end
        end else begin
          s = clock_sweep(wb, vf, vp);
          if (s < 0) expected_results.push_back(mk(StFull, 0, 0, 0, 0, 0, 1));
          else begin
            f_valid[s] = 1; f_dirty[s] = 0; f_refd[s] = 1; f_pins[s] = 1;
            f_file[s] = f; f_page[s] = p;
            expected_results.push_back(mk(StOk, s, m == ModeRead, wb, vf, vp, 1));
          end
        end
      end
      ModeUnpin: begin
        s = lookup(f, p);
        if (s < 0) expected_results.push_back(mk(StNotFound, 0, 0, 0, 0, 0, 1));
        else if (f_pins[s] == 0) expected_results.push_back(mk(StNotPinned, s, 0, 0, 0, 0, 1));
        else begin
          f_pins[s]--;
          if (md) f_dirty[s] = 1;
          expected_results.push_back(mk(StOk, s, 0, 0, 0, 0, 1));
        end
      end
      ModeDispose: begin
        s = lookup(f, p);
        if (s < 0) expected_results.push_back(mk(StNotFound, 0, 0, 0, 0, 0, 1));
        else begin
          free_frame(s);
          expected_results.push_back(mk(StOk, s, 0, 0, 0, 0, 1));
        end
      end
      ModeFlush: begin
        for (int i = 0; i < NumFrames; i++) begin
          if (!f_valid[i] || f_file[i] != f) continue;
          if (f_pins[i] != 0) begin
            expected_results.push_back(mk(StPinned, i, 0, 0, 0, 0, 1));
            return;
          end
          if (f_dirty[i]) expected_results.push_back(mk(StOk, i, 0, 1, f_file[i], f_page[i], 0));
          free_frame(i);
        end
        expected_results.push_back(mk(StOk, 0, 0, 0, 0, 0, 1));
      end
      default: ;
    endcase
  endfunction

  initial begin
    fails = 0;
    hand = NumFrames - 1;
    for (int i = 0; i < NumFrames; i++) begin
      free_frame(i); f_file[i] = '0; f_page[i] = '0;
    end
  end

  always @(posedge clk_i) begin
    result_t got, exp_r;
    if (rst_ni) begin
      if (rsp.valid && rsp.ready) begin
        got = mk(rsp.status, rsp.frame, rsp.fetch_needed, rsp.write_back,
                 rsp.victim_file, rsp.victim_page, rsp.last);
        if (expected_results.size() == 0) begin
          $error("unexpected result item %p", got);
          fails++;
        end else begin
          exp_r = expected_results.pop_front();
          if (got.status != exp_r.status) begin
            $error("status exp %0d got %0d", exp_r.status, got.status); fails++;
          end
          if (got.frame != exp_r.frame) begin
            $error("frame exp %0d got %0d", exp_r.frame, got.frame); fails++;
          end
          if (got.fetch_needed != exp_r.fetch_needed) begin
            $error("fetch_needed exp %0d got %0d", exp_r.fetch_needed, got.fetch_needed);
            fails++;
          end
          if (got.write_back != exp_r.write_back) begin
            $error("write_back exp %0d got %0d", exp_r.write_back, got.write_back); fails++;
          end
          if (got.victim_file != exp_r.victim_file) begin
            $error("victim_file exp %0h got %0h", exp_r.victim_file, got.victim_file); fails++;
          end
          if (got.victim_page != exp_r.victim_page) begin
            $error("victim_page exp %0h got %0h", exp_r.victim_page, got.victim_page); fails++;
          end
          if (got.last != exp_r.last) begin
            $error("last exp %0d got %0d", exp_r.last, got.last); fails++;
          end
        end
      end
      // predict after the compare so a same-edge result is not confused
      if (req.valid && req.ready)
        predict_request(req.mode, req.file_id, req.page_no, req.mark_dirty);
    end
  end
endmodule

// ===== tb/clock_buffer_frame_manager_tb.sv =====
// ----------------------------------------------------------------------------
// clock_buffer_frame_manager_tb
// directed and random requests against the frame manager, checked by a model
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module clock_buffer_frame_manager_tb;
  import cbfm_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_cnt, pending;
  logic flushing;

  cbfm_req_if req ();
  cbfm_rsp_if rsp ();

  clock_buffer_frame_manager u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req.sink),
    .rsp_o  (rsp.source)
  );

  cbfm_checker u_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (req),
    .rsp        (rsp),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // result side: random back-pressure, with stall-free stretches
  initial begin
    int g;
    rsp.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      rsp.ready = 1'b1;
      if (flushing || $urandom_range(0, 3) != 0) continue;
      g = gap_len();
      if (g > 0) begin
        rsp.ready = 1'b0;
        repeat (g - 1) @(negedge clk_i);
      end
    end
  end

  // drive one request item and wait for it to be taken
  task automatic send_item(logic [ModeW-1:0] m, logic [FileW-1:0] f, logic [PageW-1:0] p,
                           logic md);
    int g;
    g = gap_len();
    repeat (g) @(negedge clk_i);
    req.valid = 1'b1; req.mode = m; req.file_id = f; req.page_no = p; req.mark_dirty = md;
    do @(posedge clk_i); while (!req.ready);
    @(negedge clk_i);
    req.valid = 1'b0;
  endtask

  // idle until every expected result has arrived, then let the block settle
  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (4 * NumFrames + 8) @(negedge clk_i);
  endtask

  // a small working set of pages so hits, pins and evictions are frequent
  function automatic logic [PageW-1:0] pick_page();
    case ($urandom_range(0, 5))
      0:       return PageW'($urandom);
      1:       return {PageW{1'b1}};
      default: return PageW'($urandom_range(0, 11));
    endcase
  endfunction

  function automatic logic [FileW-1:0] pick_file();
    if ($urandom_range(0, 7) == 0) return FileW'($urandom);
    return ($urandom_range(0, 1) != 0) ? 8'hff : FileW'($urandom_range(0, 2));
  endfunction

  initial begin
    logic [ModeW-1:0] m;
    logic [FileW-1:0] f;
    logic [PageW-1:0] p;
    int sel;
    flushing = 1'b0;
    req.valid = 1'b0; req.mode = ModeRead; req.file_id = '0; req.page_no = '0;
    req.mark_dirty = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: not found on an empty table, then miss, hit, unpin, dispose
    send_item(ModeUnpin, 8'h00, 24'h0, 1'b0);
    send_item(ModeDispose, 8'hff, 24'hffffff, 1'b0);
    send_item(ModeRead, 8'h00, 24'h0, 1'b0);
    send_item(ModeRead, 8'h00, 24'h0, 1'b0);
    send_item(ModeAlloc, 8'h00, 24'h0, 1'b0);          // already present
    send_item(ModeUnpin, 8'h00, 24'h0, 1'b1);
    send_item(ModeUnpin, 8'h00, 24'h0, 1'b0);
    send_item(ModeUnpin, 8'h00, 24'h0, 1'b0);          // not pinned
    send_item(ModeAlloc, 8'hff, 24'hffffff, 1'b0);
    send_item(ModeUnpin, 8'hff, 24'hffffff, 1'b1);
    send_item(ModeFlush, 8'hff, 24'h0, 1'b0);          // one dirty write-back
    send_item(ModeDispose, 8'h00, 24'h0, 1'b0);
    send_item(3'd5, 8'h12, 24'h345678, 1'b1);          // unused modes: ignored
    send_item(3'd7, 8'hff, 24'hffffff, 1'b0);
    // fill every frame with pinned pages, then a full buffer answer
    for (int i = 0; i < NumFrames; i++) send_item(ModeRead, 8'h01, PageW'(i), 1'b0);
    send_item(ModeRead, 8'h01, 24'h100, 1'b0);
    send_item(ModeFlush, 8'h01, 24'h0, 1'b0);          // stops on a pinned frame
    drain();

    // release everything, dirty, so later sweeps write victims back
    for (int i = 0; i < NumFrames; i++)
      send_item(ModeUnpin, 8'h01, PageW'(i), 1'b1);
    drain();

    // random: mostly read/unpin on a small set, some noise
    for (int n = 0; n < 60; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 35) m = ModeRead;
      else if (sel < 65) m = ModeUnpin;
      else if (sel < 77) m = ModeAlloc;
      else if (sel < 86) m = ModeDispose;
      else if (sel < 96) m = ModeFlush;
      else m = ModeW'($urandom_range(5, 7));
      f = pick_file();
      p = pick_page();
      send_item(m, f, p, 1'($urandom));
      if (n == 30) drain();
    end

    // flush file 01 again and again while results flow freely
    flushing = 1'b1;
    for (int i = 0; i < NumFrames; i++) send_item(ModeFlush, 8'h01, 24'h0, 1'b0);
    flushing = 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (4 * NumFrames + 8) @(negedge clk_i);
    if (fail_cnt == 0) $display("clock_buffer_frame_manager_tb: clean");
    else $display("clock_buffer_frame_manager_tb: errors");
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("clock_buffer_frame_manager_tb: errors");
    $finish;
  end
endmodule
